// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the route command byte parser.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the clock edge after the antecedent.
`define RCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rcbp_pkg.sv
// Package for the route command byte parser: grammar stages, token and status codes,
// character constants, numeric limits and byte class functions. No dependencies.
`timescale 1ns / 1ps

package rcbp_pkg;

    typedef enum logic [24:0] {
        ST_TYPE      = 25'h0000001,
        ST_NID_OPEN  = 25'h0000002,
        ST_NID       = 25'h0000004,
        ST_REL_SEP   = 25'h0000008,
        ST_REL       = 25'h0000010,
        ST_ADDR_OPEN = 25'h0000020,
        ST_ADDR      = 25'h0000040,
        ST_ADDR_SEP  = 25'h0000080,
        ST_EPL_OPEN  = 25'h0000100,
        ST_EP_OPEN   = 25'h0000200,
        ST_EP        = 25'h0000400,
        ST_EP_SEP    = 25'h0000800,
        ST_EPL_SEP   = 25'h0001000,
        ST_CL_OPEN   = 25'h0002000,
        ST_C_OPEN    = 25'h0004000,
        ST_START     = 25'h0008000,
        ST_END       = 25'h0010000,
        ST_RATE      = 25'h0020000,
        ST_CEPL_OPEN = 25'h0040000,
        ST_CEP_OPEN  = 25'h0080000,
        ST_CEP       = 25'h0100000,
        ST_CEP_SEP   = 25'h0200000,
        ST_C_CLOSE   = 25'h0400000,
        ST_C_SEP     = 25'h0800000,
        ST_CMD_END   = 25'h1000000
    } stage_t;

    localparam logic [4:0] TK_NONE       = 5'd0;
    localparam logic [4:0] TK_CMD_TYPE   = 5'd1;
    localparam logic [4:0] TK_NID_CHAR   = 5'd2;
    localparam logic [4:0] TK_NID_END    = 5'd3;
    localparam logic [4:0] TK_REL        = 5'd4;
    localparam logic [4:0] TK_ADDR_CHAR  = 5'd5;
    localparam logic [4:0] TK_ADDR_END   = 5'd6;
    localparam logic [4:0] TK_EP_CHAR    = 5'd7;
    localparam logic [4:0] TK_EP_END     = 5'd8;
    localparam logic [4:0] TK_C_OPEN     = 5'd9;
    localparam logic [4:0] TK_START      = 5'd10;
    localparam logic [4:0] TK_END        = 5'd11;
    localparam logic [4:0] TK_RATE       = 5'd12;
    localparam logic [4:0] TK_CEP_CHAR   = 5'd13;
    localparam logic [4:0] TK_CEP_END    = 5'd14;
    localparam logic [4:0] TK_C_CLOSE    = 5'd15;
    localparam logic [4:0] TK_DONE       = 5'd16;
    localparam logic [4:0] TK_ERROR      = 5'd17;

    localparam logic [1:0] PS_BUSY     = 2'd0;
    localparam logic [1:0] PS_COMPLETE = 2'd1;
    localparam logic [1:0] PS_ERROR    = 2'd2;

    localparam logic REG_CMD_TYPE_MIN = 1'b0;
    localparam logic REG_CMD_TYPE_MAX = 1'b1;

    localparam logic [7:0] CMD_TYPE_MIN_RST = 8'd1;
    localparam logic [7:0] CMD_TYPE_MAX_RST = 8'd4;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [63:0] REL_MIN    = 64'd100;
    localparam logic [63:0] REL_MAX    = 64'd1000;
    localparam logic [63:0] TIME_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;

    typedef struct packed {
        logic [63:0] acc_digit;
        logic [63:0] time_ms;
        logic        time_ok;
        logic        rel_ok;
    } num_info_t;

    function automatic logic is_uri_byte(input logic [7:0] b);
        return b inside {[8'h21:8'h5F], [8'h61:8'h7A], 8'h7E};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

endpackage

// File: rtl/rcbp_number_unit.sv
// Numeric helper of the route command byte parser: saturating decimal accumulate,
// time scaling by 1000 and range checks. Depends on rcbp_pkg.
`timescale 1ns / 1ps

module rcbp_number_unit (
    input  logic [63:0]        acc,
    input  logic [7:0]         digit_byte,
    output rcbp_pkg::num_info_t info
);

    logic [67:0] acc_wide;
    logic [67:0] times_ten;

    assign acc_wide  = {4'b0000, acc};
    assign times_ten = (acc_wide << 3) + (acc_wide << 1) + {64'd0, digit_byte[3:0]};

    // A carry above bit 63 means the decimal value no longer fits, so it saturates.
    assign info.acc_digit = (|times_ten[67:64]) ? {64{1'b1}} : times_ten[63:0];
    assign info.time_ms   = (acc << 10) - (acc << 4) - (acc << 3);
    assign info.time_ok   = acc < rcbp_pkg::TIME_LIMIT;
    assign info.rel_ok    = (acc >= rcbp_pkg::REL_MIN) && (acc <= rcbp_pkg::REL_MAX);

endmodule

// File: rtl/route_command_byte_parser.sv
// Top level of the route command byte parser: input register, grammar state machine,
// result register and APB configuration port. Depends on rcbp_pkg, rcbp_number_unit
// and assert_macros.svh.
//
// Usage: each input transaction carries one byte of a route command (data_byte) and a
// restart flag. Every input transaction yields exactly one output transaction with a
// token kind, a token value and the parse status. A restart transaction returns the
// parser to the command type stage and its byte is ignored.
// A transaction in the input register is processed into the result register once that
// register is free. Throughput: one transaction per cycle while the receiver takes results;
// the grammar stage and digit accumulator update as each transaction is processed, and the
// input side keeps accepting while a result waits. When the receiver stalls, the result
// register holds its transaction and the input register fills; input ready drops only once
// both are occupied. Reset clears the grammar state, accumulator, both registers' valid
// flags and sets the command type limits to 1 and 4. The limits are written over the APB
// port at byte addresses 0 (minimum) and 4 (maximum); the user must write them only while
// the parser is idle, since the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module route_command_byte_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [63:0] token_value,
    output logic [1:0]  parse_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 cfg_sel_min;
    logic [7:0]           cmd_type_min_reg;
    logic [7:0]           cmd_type_max_reg;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 restart_reg;

    rcbp_pkg::stage_t     stage_reg;
    rcbp_pkg::stage_t     stage_next;
    rcbp_pkg::stage_t     gram_stage;
    logic                 finished_reg;
    logic                 finished_next;
    logic [63:0]          acc_reg;
    logic [63:0]          acc_next;
    logic [63:0]          gram_acc;

    logic                 out_valid_reg;
    logic [4:0]           kind_reg;
    logic [4:0]           kind_next;
    logic [63:0]          value_reg;
    logic [63:0]          value_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    logic [4:0]           gram_kind;
    logic [63:0]          gram_val;
    logic                 gram_err;
    logic                 gram_done;
    logic                 out_free;
    logic                 fire;
    logic                 cfg_write;

    rcbp_pkg::num_info_t  num;

    assign cfg_sel_min = (paddr[2] == rcbp_pkg::REG_CMD_TYPE_MIN);
    assign cfg_write   = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = cfg_sel_min ? {24'd0, cmd_type_min_reg} : {24'd0, cmd_type_max_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_type_min_reg <= rcbp_pkg::CMD_TYPE_MIN_RST;
            cmd_type_max_reg <= rcbp_pkg::CMD_TYPE_MAX_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_sel_min)
            begin
                cmd_type_min_reg <= pwdata[7:0];
            end
            else
            begin
                cmd_type_max_reg <= pwdata[7:0];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= data_byte;
            restart_reg <= restart;
        end
    end

    rcbp_number_unit u_number (
        .acc        (acc_reg),
        .digit_byte (byte_reg),
        .info       (num)
    );

    always_comb
    begin
        gram_kind  = rcbp_pkg::TK_NONE;
        gram_val   = '0;
        gram_stage = stage_reg;
        gram_acc   = acc_reg;
        gram_err   = 1'b0;
        gram_done  = 1'b0;
        case (stage_reg)
            rcbp_pkg::ST_TYPE:
            begin
                if (byte_reg >= cmd_type_min_reg && byte_reg <= cmd_type_max_reg)
                begin
                    gram_kind  = rcbp_pkg::TK_CMD_TYPE;
                    gram_val   = {56'd0, byte_reg};
                    gram_stage = rcbp_pkg::ST_NID_OPEN;
                end
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_NID_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LPAREN) gram_stage = rcbp_pkg::ST_NID;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_NID:
            begin
                if (byte_reg == rcbp_pkg::CH_RPAREN)
                begin
                    gram_kind  = rcbp_pkg::TK_NID_END;
                    gram_stage = rcbp_pkg::ST_REL_SEP;
                end
                else if (rcbp_pkg::is_uri_byte(byte_reg))
                begin
                    gram_kind = rcbp_pkg::TK_NID_CHAR;
                    gram_val  = {56'd0, byte_reg};
                end
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_REL_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA)
                begin
                    gram_acc   = '0;
                    gram_stage = rcbp_pkg::ST_REL;
                end
                else if (byte_reg == rcbp_pkg::CH_COLON) gram_stage = rcbp_pkg::ST_ADDR_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_REL:
            begin
                if (byte_reg == rcbp_pkg::CH_COLON || byte_reg == rcbp_pkg::CH_SEMI)
                begin
                    if (!num.rel_ok) gram_err = 1'b1;
                    else
                    begin
                        gram_val   = acc_reg;
                        gram_stage = rcbp_pkg::ST_ADDR_OPEN;
                        if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                        else gram_kind = rcbp_pkg::TK_REL;
                    end
                end
                else if (rcbp_pkg::is_digit(byte_reg)) gram_acc = num.acc_digit;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_ADDR_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LPAREN) gram_stage = rcbp_pkg::ST_ADDR;
                else if (byte_reg == rcbp_pkg::CH_COLON) gram_stage = rcbp_pkg::ST_EPL_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_ADDR:
            begin
                if (byte_reg == rcbp_pkg::CH_RPAREN)
                begin
                    gram_kind  = rcbp_pkg::TK_ADDR_END;
                    gram_stage = rcbp_pkg::ST_ADDR_SEP;
                end
                else
                begin
                    gram_kind = rcbp_pkg::TK_ADDR_CHAR;
                    gram_val  = {56'd0, byte_reg};
                end
            end
            rcbp_pkg::ST_ADDR_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COLON) gram_stage = rcbp_pkg::ST_EPL_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_EPL_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LBRACK) gram_stage = rcbp_pkg::ST_EP_OPEN;
                else if (byte_reg == rcbp_pkg::CH_COLON) gram_stage = rcbp_pkg::ST_CL_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_EP_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LPAREN) gram_stage = rcbp_pkg::ST_EP;
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_EPL_SEP;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_EP:
            begin
                if (byte_reg == rcbp_pkg::CH_RPAREN)
                begin
                    gram_kind  = rcbp_pkg::TK_EP_END;
                    gram_stage = rcbp_pkg::ST_EP_SEP;
                end
                else if (rcbp_pkg::is_uri_byte(byte_reg))
                begin
                    gram_kind = rcbp_pkg::TK_EP_CHAR;
                    gram_val  = {56'd0, byte_reg};
                end
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_EP_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA) gram_stage = rcbp_pkg::ST_EP_OPEN;
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_EPL_SEP;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_EPL_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COLON) gram_stage = rcbp_pkg::ST_CL_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CL_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LBRACK) gram_stage = rcbp_pkg::ST_C_OPEN;
                else if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_C_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LBRACE)
                begin
                    gram_kind  = rcbp_pkg::TK_C_OPEN;
                    gram_acc   = '0;
                    gram_stage = rcbp_pkg::ST_START;
                end
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_CMD_END;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_START, rcbp_pkg::ST_END:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA)
                begin
                    if (!num.time_ok) gram_err = 1'b1;
                    else
                    begin
                        gram_val = num.time_ms;
                        gram_acc = '0;
                        if (stage_reg == rcbp_pkg::ST_START)
                        begin
                            gram_kind  = rcbp_pkg::TK_START;
                            gram_stage = rcbp_pkg::ST_END;
                        end
                        else
                        begin
                            gram_kind  = rcbp_pkg::TK_END;
                            gram_stage = rcbp_pkg::ST_RATE;
                        end
                    end
                end
                else if (rcbp_pkg::is_digit(byte_reg)) gram_acc = num.acc_digit;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_RATE:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA || byte_reg == rcbp_pkg::CH_RBRACE)
                begin
                    gram_kind = rcbp_pkg::TK_RATE;
                    gram_val  = {32'd0, acc_reg[31:0]};
                    if (byte_reg == rcbp_pkg::CH_COMMA) gram_stage = rcbp_pkg::ST_CEPL_OPEN;
                    else gram_stage = rcbp_pkg::ST_C_SEP;
                end
                else if (rcbp_pkg::is_digit(byte_reg)) gram_acc = num.acc_digit;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CEPL_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LBRACK) gram_stage = rcbp_pkg::ST_CEP_OPEN;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CEP_OPEN:
            begin
                if (byte_reg == rcbp_pkg::CH_LPAREN) gram_stage = rcbp_pkg::ST_CEP;
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_C_CLOSE;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CEP:
            begin
                if (byte_reg == rcbp_pkg::CH_RPAREN)
                begin
                    gram_kind  = rcbp_pkg::TK_CEP_END;
                    gram_stage = rcbp_pkg::ST_CEP_SEP;
                end
                else if (rcbp_pkg::is_uri_byte(byte_reg))
                begin
                    gram_kind = rcbp_pkg::TK_CEP_CHAR;
                    gram_val  = {56'd0, byte_reg};
                end
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CEP_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA) gram_stage = rcbp_pkg::ST_CEP_OPEN;
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_C_CLOSE;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_C_CLOSE:
            begin
                if (byte_reg == rcbp_pkg::CH_RBRACE)
                begin
                    gram_kind  = rcbp_pkg::TK_C_CLOSE;
                    gram_stage = rcbp_pkg::ST_C_SEP;
                end
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_C_SEP:
            begin
                if (byte_reg == rcbp_pkg::CH_COMMA) gram_stage = rcbp_pkg::ST_C_OPEN;
                else if (byte_reg == rcbp_pkg::CH_RBRACK) gram_stage = rcbp_pkg::ST_CMD_END;
                else gram_err = 1'b1;
            end
            rcbp_pkg::ST_CMD_END:
            begin
                if (byte_reg == rcbp_pkg::CH_SEMI) gram_done = 1'b1;
                else gram_err = 1'b1;
            end
            default:
            begin
                gram_err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        stage_next    = stage_reg;
        finished_next = finished_reg;
        acc_next      = acc_reg;
        kind_next     = rcbp_pkg::TK_NONE;
        value_next    = '0;
        status_next   = rcbp_pkg::PS_BUSY;
        if (restart_reg)
        begin
            stage_next    = rcbp_pkg::ST_TYPE;
            finished_next = 1'b0;
            acc_next      = '0;
        end
        else if (finished_reg)
        begin
            status_next = rcbp_pkg::PS_COMPLETE;
        end
        else if (gram_err)
        begin
            stage_next    = rcbp_pkg::ST_TYPE;
            finished_next = 1'b0;
            acc_next      = '0;
            kind_next     = rcbp_pkg::TK_ERROR;
            value_next    = {56'd0, byte_reg};
            status_next   = rcbp_pkg::PS_ERROR;
        end
        else if (gram_done)
        begin
            stage_next    = gram_stage;
            finished_next = 1'b1;
            acc_next      = gram_acc;
            kind_next     = rcbp_pkg::TK_DONE;
            value_next    = gram_val;
            status_next   = rcbp_pkg::PS_COMPLETE;
        end
        else
        begin
            stage_next = gram_stage;
            acc_next   = gram_acc;
            kind_next  = gram_kind;
            value_next = gram_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= rcbp_pkg::ST_TYPE;
            finished_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                stage_reg    <= stage_next;
                finished_reg <= finished_next;
                acc_reg      <= acc_next;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_value  = value_reg;
    assign parse_status = status_reg;

    `RCBP_ASSERT(a_stage_onehot, clk, rst_n, $onehot(stage_reg), "grammar stage is not one-hot")
    `RCBP_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid_reg,
        "processed transaction did not reach the result register")
    `RCBP_ASSERT_NEXT(a_error_clears, clk, rst_n, fire && !restart_reg && !finished_reg && gram_err,
        stage_reg == rcbp_pkg::ST_TYPE && acc_reg == 64'd0 && status_reg == rcbp_pkg::PS_ERROR,
        "error did not return the parser to the command start")
    `RCBP_ASSERT_NEXT(a_finished_sticky, clk, rst_n, finished_reg && !(fire && restart_reg),
        finished_reg, "completed command state was lost without restart")
    `RCBP_ASSERT(a_input_free_ready, clk, rst_n, !in_valid_reg |-> in_ready,
        "input register empty but not ready")

endmodule

// File: sim/tb_route_command_byte_parser.sv
// Self-checking testbench for route_command_byte_parser: directed and random byte streams,
// type window changes over APB, random stalls on both handshakes, scoreboard of tokens.
// Depends on rcbp_pkg and the RTL of route_command_byte_parser.
`timescale 1ns / 1ps

module tb_route_command_byte_parser;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] value;
        logic [1:0]  status;
    } tok_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_restart;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  token_kind;
    logic [63:0] token_value;
    logic [1:0]  parse_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rcbp_pkg::stage_t parse_stage;
    logic        parse_done;
    logic [63:0] digit_sum;
    logic [7:0]  type_lo;
    logic [7:0]  type_hi;

    tok_t        expected_tokens[$];
    item_t       script_q[$];
    tok_t        want_tok;

    int error_count = 0;
    int tokens_checked = 0;
    int live_bytes = 0;
    int commands_done = 0;
    int commands_rejected = 0;
    int windows_used = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int ready_run = 0;
    int ready_pick = 0;

    route_command_byte_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .parse_status (parse_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    function automatic logic uri_char(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h5F) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h7E;
    endfunction

    function automatic logic dec_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [63:0] shift_in_digit(input logic [63:0] sum, input logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - 8'h30};
        if (sum > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return sum * 64'd10 + d;
    endfunction

    function automatic void clear_parser();
        parse_stage = rcbp_pkg::ST_TYPE;
        parse_done = 1'b0;
        digit_sum = 64'd0;
    endfunction

    function automatic tok_t parse_byte(input logic [7:0] b, input logic rs);
        tok_t t;
        rcbp_pkg::stage_t nxt;
        logic err;
        logic fin;
        logic [63:0] acc;
        t.kind = rcbp_pkg::TK_NONE;
        t.value = 64'd0;
        t.status = rcbp_pkg::PS_BUSY;
        nxt = parse_stage;
        err = 1'b0;
        fin = 1'b0;
        acc = digit_sum;
        if (rs)
        begin
            clear_parser();
            return t;
        end
        if (parse_done)
        begin
            t.status = rcbp_pkg::PS_COMPLETE;
            return t;
        end
        case (parse_stage)
            rcbp_pkg::ST_TYPE:
                if (b >= type_lo && b <= type_hi)
                begin
                    t.kind = rcbp_pkg::TK_CMD_TYPE;
                    t.value = {56'd0, b};
                    nxt = rcbp_pkg::ST_NID_OPEN;
                end
                else
                    err = 1'b1;
            rcbp_pkg::ST_NID_OPEN:
                if (b == rcbp_pkg::CH_LPAREN) nxt = rcbp_pkg::ST_NID; else err = 1'b1;
            rcbp_pkg::ST_NID:
                if (b == rcbp_pkg::CH_RPAREN)
                begin
                    t.kind = rcbp_pkg::TK_NID_END;
                    nxt = rcbp_pkg::ST_REL_SEP;
                end
                else if (uri_char(b))
                begin
                    t.kind = rcbp_pkg::TK_NID_CHAR;
                    t.value = {56'd0, b};
                end
                else
                    err = 1'b1;
            rcbp_pkg::ST_REL_SEP:
                if (b == rcbp_pkg::CH_COMMA)
                begin
                    digit_sum = 64'd0;
                    nxt = rcbp_pkg::ST_REL;
                end
                else if (b == rcbp_pkg::CH_COLON) nxt = rcbp_pkg::ST_ADDR_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_REL:
                if (b == rcbp_pkg::CH_COLON || b == rcbp_pkg::CH_SEMI)
                begin
                    if (acc < rcbp_pkg::REL_MIN || acc > rcbp_pkg::REL_MAX)
                        err = 1'b1;
                    else
                    begin
                        t.value = acc;
                        nxt = rcbp_pkg::ST_ADDR_OPEN;
                        if (b == rcbp_pkg::CH_SEMI) fin = 1'b1; else t.kind = rcbp_pkg::TK_REL;
                    end
                end
                else if (dec_digit(b)) digit_sum = shift_in_digit(digit_sum, b);
                else err = 1'b1;
            rcbp_pkg::ST_ADDR_OPEN:
                if (b == rcbp_pkg::CH_LPAREN) nxt = rcbp_pkg::ST_ADDR;
                else if (b == rcbp_pkg::CH_COLON) nxt = rcbp_pkg::ST_EPL_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_ADDR:
                if (b == rcbp_pkg::CH_RPAREN)
                begin
                    t.kind = rcbp_pkg::TK_ADDR_END;
                    nxt = rcbp_pkg::ST_ADDR_SEP;
                end
                else
                begin
                    t.kind = rcbp_pkg::TK_ADDR_CHAR;
                    t.value = {56'd0, b};
                end
            rcbp_pkg::ST_ADDR_SEP:
                if (b == rcbp_pkg::CH_COLON) nxt = rcbp_pkg::ST_EPL_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_EPL_OPEN:
                if (b == rcbp_pkg::CH_LBRACK) nxt = rcbp_pkg::ST_EP_OPEN;
                else if (b == rcbp_pkg::CH_COLON) nxt = rcbp_pkg::ST_CL_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_EP_OPEN:
                if (b == rcbp_pkg::CH_LPAREN) nxt = rcbp_pkg::ST_EP;
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_EPL_SEP;
                else err = 1'b1;
            rcbp_pkg::ST_EP:
                if (b == rcbp_pkg::CH_RPAREN)
                begin
                    t.kind = rcbp_pkg::TK_EP_END;
                    nxt = rcbp_pkg::ST_EP_SEP;
                end
                else if (uri_char(b))
                begin
                    t.kind = rcbp_pkg::TK_EP_CHAR;
                    t.value = {56'd0, b};
                end
                else
                    err = 1'b1;
            rcbp_pkg::ST_EP_SEP:
                if (b == rcbp_pkg::CH_COMMA) nxt = rcbp_pkg::ST_EP_OPEN;
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_EPL_SEP;
                else err = 1'b1;
            rcbp_pkg::ST_EPL_SEP:
                if (b == rcbp_pkg::CH_COLON) nxt = rcbp_pkg::ST_CL_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_CL_OPEN:
                if (b == rcbp_pkg::CH_LBRACK) nxt = rcbp_pkg::ST_C_OPEN;
                else if (b == rcbp_pkg::CH_SEMI) fin = 1'b1;
                else err = 1'b1;
            rcbp_pkg::ST_C_OPEN:
                if (b == rcbp_pkg::CH_LBRACE)
                begin
                    t.kind = rcbp_pkg::TK_C_OPEN;
                    digit_sum = 64'd0;
                    nxt = rcbp_pkg::ST_START;
                end
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_CMD_END;
                else err = 1'b1;
            rcbp_pkg::ST_START, rcbp_pkg::ST_END:
                if (b == rcbp_pkg::CH_COMMA)
                begin
                    if (acc >= rcbp_pkg::TIME_LIMIT)
                        err = 1'b1;
                    else
                    begin
                        t.value = acc * 64'd1000;
                        t.kind = (parse_stage == rcbp_pkg::ST_START) ?
                                 rcbp_pkg::TK_START : rcbp_pkg::TK_END;
                        nxt = (parse_stage == rcbp_pkg::ST_START) ?
                              rcbp_pkg::ST_END : rcbp_pkg::ST_RATE;
                        digit_sum = 64'd0;
                    end
                end
                else if (dec_digit(b)) digit_sum = shift_in_digit(digit_sum, b);
                else err = 1'b1;
            rcbp_pkg::ST_RATE:
                if (b == rcbp_pkg::CH_COMMA || b == rcbp_pkg::CH_RBRACE)
                begin
                    t.kind = rcbp_pkg::TK_RATE;
                    t.value = {32'd0, acc[31:0]};
                    nxt = (b == rcbp_pkg::CH_COMMA) ? rcbp_pkg::ST_CEPL_OPEN : rcbp_pkg::ST_C_SEP;
                end
                else if (dec_digit(b)) digit_sum = shift_in_digit(digit_sum, b);
                else err = 1'b1;
            rcbp_pkg::ST_CEPL_OPEN:
                if (b == rcbp_pkg::CH_LBRACK) nxt = rcbp_pkg::ST_CEP_OPEN; else err = 1'b1;
            rcbp_pkg::ST_CEP_OPEN:
                if (b == rcbp_pkg::CH_LPAREN) nxt = rcbp_pkg::ST_CEP;
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_C_CLOSE;
                else err = 1'b1;
            rcbp_pkg::ST_CEP:
                if (b == rcbp_pkg::CH_RPAREN)
                begin
                    t.kind = rcbp_pkg::TK_CEP_END;
                    nxt = rcbp_pkg::ST_CEP_SEP;
                end
                else if (uri_char(b))
                begin
                    t.kind = rcbp_pkg::TK_CEP_CHAR;
                    t.value = {56'd0, b};
                end
                else
                    err = 1'b1;
            rcbp_pkg::ST_CEP_SEP:
                if (b == rcbp_pkg::CH_COMMA) nxt = rcbp_pkg::ST_CEP_OPEN;
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_C_CLOSE;
                else err = 1'b1;
            rcbp_pkg::ST_C_CLOSE:
                if (b == rcbp_pkg::CH_RBRACE)
                begin
                    t.kind = rcbp_pkg::TK_C_CLOSE;
                    nxt = rcbp_pkg::ST_C_SEP;
                end
                else
                    err = 1'b1;
            rcbp_pkg::ST_C_SEP:
                if (b == rcbp_pkg::CH_COMMA) nxt = rcbp_pkg::ST_C_OPEN;
                else if (b == rcbp_pkg::CH_RBRACK) nxt = rcbp_pkg::ST_CMD_END;
                else err = 1'b1;
            rcbp_pkg::ST_CMD_END:
                if (b == rcbp_pkg::CH_SEMI) fin = 1'b1; else err = 1'b1;
            default:
                err = 1'b1;
        endcase
        if (err)
        begin
            clear_parser();
            t.kind = rcbp_pkg::TK_ERROR;
            t.value = {56'd0, b};
            t.status = rcbp_pkg::PS_ERROR;
            return t;
        end
        parse_stage = nxt;
        if (fin)
        begin
            parse_done = 1'b1;
            t.kind = rcbp_pkg::TK_DONE;
            t.status = rcbp_pkg::PS_COMPLETE;
        end
        return t;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        if (r < 97)
        begin
            burst_left = $urandom_range(30, 100);
            return 0;
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic string nines(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, "9"};
        return s;
    endfunction

    function automatic string rel_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $sformatf("%0d", $urandom_range(100, 1000));
        if (r < 83) return "99";
        if (r < 86) return "100";
        if (r < 89) return "1000";
        if (r < 92) return "1001";
        if (r < 94) return "";
        if (r < 97) return "0000250";
        return nines(22);
    endfunction

    function automatic string time_text();
        int r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (r < 85) return $sformatf("%0d", $urandom_range(0, 200000));
        if (r < 88) return $sformatf("%0d", rcbp_pkg::TIME_LIMIT - 64'd1);
        if (r < 90) return $sformatf("%0d", rcbp_pkg::TIME_LIMIT);
        if (r < 92) return $sformatf("%0d", v);
        if (r < 95) return "";
        if (r < 97) return "18446744073709551615";
        if (r < 98) return "18446744073709551616";
        return nines(25);
    endfunction

    function automatic string rate_text();
        int r;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (r < 60) return $sformatf("%0d", v[31:0]);
        if (r < 72) return $sformatf("%0d", v);
        if (r < 78) return "4294967296";
        if (r < 84) return "";
        if (r < 90) return "4294967295";
        return nines(30);
    endfunction

    function automatic logic [7:0] id_char();
        logic [7:0] b;
        if (chance(92))
        begin
            do
            begin
                b = 8'($urandom_range(8'h21, 8'h7E));
            end
            while (!uri_char(b) || b == rcbp_pkg::CH_RPAREN);
            return b;
        end
        case ($urandom_range(0, 3))
            0: b = 8'($urandom_range(8'h00, 8'h20));
            1: b = 8'h60;
            2: b = 8'($urandom_range(8'h7B, 8'h7D));
            default: b = 8'($urandom_range(8'h7F, 8'hFF));
        endcase
        return b;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        script_q.push_back('{b, 1'b0});
    endfunction

    function automatic void push_restart();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        script_q.push_back('{b, 1'b1});
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_id();
        int n;
        n = $urandom_range(0, 5);
        push_byte(rcbp_pkg::CH_LPAREN);
        for (int i = 0; i < n; i++)
            push_byte(id_char());
        push_byte(rcbp_pkg::CH_RPAREN);
    endfunction

    function automatic void push_id_list();
        int n;
        n = $urandom_range(0, 3);
        push_byte(rcbp_pkg::CH_LBRACK);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                push_byte(rcbp_pkg::CH_COMMA);
            push_id();
        end
        if (n > 0 && chance(5))
            push_byte(rcbp_pkg::CH_COMMA);
        push_byte(rcbp_pkg::CH_RBRACK);
    endfunction

    task automatic build_command();
        logic [7:0] b;
        int n;
        if (type_lo <= type_hi && chance(90))
            b = 8'($urandom_range(type_hi, type_lo));
        else
            b = 8'($urandom_range(0, 255));
        push_byte(b);
        push_id();
        if (chance(40))
        begin
            push_byte(rcbp_pkg::CH_COMMA);
            push_text(rel_text());
            if (chance(25))
            begin
                push_byte(rcbp_pkg::CH_SEMI);
                return;
            end
        end
        else if (chance(15))
        begin
            push_byte(rcbp_pkg::CH_SEMI);
            return;
        end
        push_byte(rcbp_pkg::CH_COLON);
        if (chance(10))
        begin
            push_byte(rcbp_pkg::CH_SEMI);
            return;
        end
        if (chance(60))
        begin
            n = $urandom_range(0, 6);
            push_byte(rcbp_pkg::CH_LPAREN);
            for (int i = 0; i < n; i++)
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (b == rcbp_pkg::CH_RPAREN);
                push_byte(b);
            end
            push_byte(rcbp_pkg::CH_RPAREN);
            if (chance(10))
            begin
                push_byte(rcbp_pkg::CH_SEMI);
                return;
            end
        end
        push_byte(rcbp_pkg::CH_COLON);
        if (chance(10))
        begin
            push_byte(rcbp_pkg::CH_SEMI);
            return;
        end
        if (chance(60))
        begin
            push_id_list();
            if (chance(10))
            begin
                push_byte(rcbp_pkg::CH_SEMI);
                return;
            end
        end
        push_byte(rcbp_pkg::CH_COLON);
        if (chance(10))
        begin
            push_byte(rcbp_pkg::CH_SEMI);
            return;
        end
        push_byte(rcbp_pkg::CH_LBRACK);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                push_byte(rcbp_pkg::CH_COMMA);
            push_byte(rcbp_pkg::CH_LBRACE);
            push_text(time_text());
            push_byte(rcbp_pkg::CH_COMMA);
            push_text(time_text());
            push_byte(rcbp_pkg::CH_COMMA);
            push_text(rate_text());
            if (chance(40))
            begin
                push_byte(rcbp_pkg::CH_COMMA);
                push_id_list();
            end
            push_byte(rcbp_pkg::CH_RBRACE);
        end
        push_byte(rcbp_pkg::CH_RBRACK);
        push_byte(rcbp_pkg::CH_SEMI);
    endtask

    task automatic send_item(input logic [7:0] b, input logic rs);
        tok_t t;
        int gap;
        data_byte <= b;
        restart <= rs;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (!rs && !parse_done)
            live_bytes++;
        t = parse_byte(b, rs);
        expected_tokens.push_back(t);
        if (t.kind == rcbp_pkg::TK_DONE)
            commands_done++;
        if (t.kind == rcbp_pkg::TK_ERROR)
            commands_rejected++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic play_script();
        item_t it;
        while (script_q.size() != 0)
        begin
            it = script_q.pop_front();
            send_item(it.data, it.is_restart);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        logic [23:0] junk;
        junk = 24'($urandom);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {junk, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == rcbp_pkg::REG_CMD_TYPE_MIN)
            type_lo = val;
        else
            type_hi = val;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [7:0] lo, input logic [7:0] hi);
        wait_drained();
        write_reg(rcbp_pkg::REG_CMD_TYPE_MIN, lo);
        write_reg(rcbp_pkg::REG_CMD_TYPE_MAX, hi);
        windows_used++;
    endtask

    task automatic test_type_and_restart();
        push_restart();
        push_byte(8'h00);
        push_byte(8'h05);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h04);
        push_byte(rcbp_pkg::CH_LPAREN);
        push_byte(8'h7E);
        push_byte(8'h7F);
        play_script();
    endtask

    task automatic test_reliability_field();
        push_byte(8'h02);
        push_text("(),;");
        push_byte(8'h03);
        push_text("(A),1000;");
        push_byte(8'h55);
        push_restart();
        play_script();
    endtask

    task automatic test_type_window();
        set_window(8'h00, 8'h00);
        push_byte(8'h00);
        push_restart();
        push_byte(8'h01);
        play_script();
        set_window(8'hFF, 8'hFF);
        push_byte(8'hFF);
        push_restart();
        push_byte(8'hFE);
        play_script();
    endtask

    task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi, input int count);
        int target;
        int pos;
        int r;
        set_window(lo, hi);
        target = live_bytes + count;
        while (live_bytes < target)
        begin
            build_command();
            r = $urandom_range(0, 99);
            pos = $urandom_range(1, script_q.size() - 1);
            if (r < 10)
                script_q[pos].data = 8'($urandom_range(0, 255));
            else if (r < 14)
                script_q.insert(pos, '{8'h00, 1'b1});
            else if (r < 18)
                while (script_q.size() > pos)
                    void'(script_q.pop_back());
            play_script();
            if (parse_done || chance(40))
            begin
                repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
                push_restart();
                play_script();
            end
            if (chance(3))
                wait_drained();
        end
    endtask

    task automatic test_random_commands();
        logic [7:0] lo;
        logic [7:0] hi;
        run_phase(8'h00, 8'hFF, 300);
        run_phase(rcbp_pkg::CMD_TYPE_MIN_RST, rcbp_pkg::CMD_TYPE_MAX_RST, 200);
        run_phase(8'hFF, 8'hFF, 120);
        run_phase(8'h00, 8'h00, 120);
        run_phase(8'hC8, 8'h64, 30);
        lo = 8'($urandom_range(0, 255));
        hi = 8'($urandom_range(255, lo));
        run_phase(lo, hi, 200);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (ready_run > 0)
        begin
            out_ready <= 1'b1;
            ready_run--;
        end
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 50)
                out_ready <= 1'b1;
            else if (ready_pick < 80)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else if (ready_pick < 95)
            begin
                out_ready <= 1'b1;
                ready_run = $urandom_range(20, 80);
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tokens_checked++;
            if (expected_tokens.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected token: kind %0d value 0x%h status %0d",
                             token_kind, token_value, parse_status);
            end
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (token_kind !== want_tok.kind || token_value !== want_tok.value ||
                    parse_status !== want_tok.status)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("token %0d mismatch: expected kind %0d value 0x%h status %0d",
                                 tokens_checked, want_tok.kind, want_tok.value,
                                 want_tok.status);
                        $display("    got kind %0d value 0x%h status %0d",
                                 token_kind, token_value, parse_status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_route_command_byte_parser: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        type_lo = rcbp_pkg::CMD_TYPE_MIN_RST;
        type_hi = rcbp_pkg::CMD_TYPE_MAX_RST;
        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_type_and_restart();
        test_reliability_field();
        test_type_window();
        test_random_commands();
        wait_drained();
        $display("Checked %0d tokens from %0d live bytes: %0d commands finished, %0d rejected.",
                 tokens_checked, live_bytes, commands_done, commands_rejected);
        $display("Command type window was reprogrammed %0d times, including the 0 and 255 edges.",
                 windows_used);
        if (error_count == 0)
            $display("tb_route_command_byte_parser: done, clean");
        else
            $display("tb_route_command_byte_parser: done, errors");
        $finish;
    end

endmodule
